// ===== rtl/psqp_pkg.sv =====
// Shared types and constants of the path segment to quadratic primitive converter.
// Holds the command codes, the internal job codes and the primitive kind codes.
// No dependencies.
package psqp_pkg;

    typedef enum logic [2:0] {
        ACT_MOVE  = 3'd0,
        ACT_LINE  = 3'd1,
        ACT_QUAD  = 3'd2,
        ACT_CUBIC = 3'd3,
        ACT_CLOSE = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_QUAD  = 2'd1,
        OP_CUBIC = 2'd2
    } t_op;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_QUAD = 1'b1;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;

endpackage

// ===== rtl/path_segments_to_quad_primitives.sv =====
// Top level of the path segment to quadratic primitive converter.
// Instantiates psqp_front, psqp_fifo (twice) and psqp_back; depends on psqp_pkg.
//
//   Channel   Handshake          Payload
//   command   i_push / o_full    i_action, i_point{1,2,3}_{x,y}
//   primitive o_empty / i_pop    o_kind, o_begin_*, o_ctrl_*, o_finish_*, o_last
//
// A line, quad or close request yields one primitive and a cubic four; the emitter issues one
// primitive per cycle while the output queue has room. Moves and ignored requests yield nothing.
// The first primitive passes the job queue, the back pipeline and the output queue to the ports.
// Reset clears the pen state, queue pointers and pipeline valid bits; nothing is swept.
// The front stalls only when the job queue is full; the back stalls on a full output queue.
module path_segments_to_quad_primitives #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [2:0]                    i_action,
    input  logic signed [COORD_WIDTH-1:0] i_point1_x,
    input  logic signed [COORD_WIDTH-1:0] i_point1_y,
    input  logic signed [COORD_WIDTH-1:0] i_point2_x,
    input  logic signed [COORD_WIDTH-1:0] i_point2_y,
    input  logic signed [COORD_WIDTH-1:0] i_point3_x,
    input  logic signed [COORD_WIDTH-1:0] i_point3_y,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_kind,
    output logic signed [COORD_WIDTH-1:0] o_begin_x,
    output logic signed [COORD_WIDTH-1:0] o_begin_y,
    output logic signed [COORD_WIDTH-1:0] o_ctrl_x,
    output logic signed [COORD_WIDTH-1:0] o_ctrl_y,
    output logic signed [COORD_WIDTH-1:0] o_finish_x,
    output logic signed [COORD_WIDTH-1:0] o_finish_y,
    output logic                          o_last
);

    import psqp_pkg::*;

    localparam int JOB_W    = $bits(t_op) + 8 * COORD_WIDTH;
    localparam int PRIM_W   = 2 + 6 * COORD_WIDTH;
    localparam int JOB_DEP  = 4;
    localparam int PRIM_DEP = 4;

    typedef logic [1:0][COORD_WIDTH-1:0] t_pt;

    typedef struct packed {
        logic kind;
        t_pt  bgn;
        t_pt  ctl;
        t_pt  fin;
        logic last;
    } t_prim;

    logic              w_job_push;
    logic [JOB_W-1:0]  w_job_in;
    logic [JOB_W-1:0]  w_job_out;
    logic              w_job_empty;
    logic              w_job_pop;
    logic              w_prim_push;
    logic [PRIM_W-1:0] w_prim_in;
    logic              w_prim_full;
    t_prim             w_prim_out;

    psqp_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_action   (i_action),
        .i_point1_x (i_point1_x),
        .i_point1_y (i_point1_y),
        .i_point2_x (i_point2_x),
        .i_point2_y (i_point2_y),
        .i_point3_x (i_point3_x),
        .i_point3_y (i_point3_y),
        .i_full     (o_full),
        .o_push     (w_job_push),
        .o_job      (w_job_in)
    );

    psqp_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEP)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (o_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    psqp_back #(
        .CW (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_prim_full (w_prim_full),
        .o_prim_push (w_prim_push),
        .o_prim      (w_prim_in)
    );

    psqp_fifo #(
        .WIDTH (PRIM_W),
        .DEPTH (PRIM_DEP)
    ) u_prim_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_prim_push),
        .i_data  (w_prim_in),
        .o_full  (w_prim_full),
        .i_pop   (i_pop),
        .o_data  (w_prim_out),
        .o_empty (o_empty)
    );

    assign o_kind     = w_prim_out.kind;
    assign o_begin_x  = w_prim_out.bgn[AX_X];
    assign o_begin_y  = w_prim_out.bgn[AX_Y];
    assign o_ctrl_x   = w_prim_out.ctl[AX_X];
    assign o_ctrl_y   = w_prim_out.ctl[AX_Y];
    assign o_finish_x = w_prim_out.fin[AX_X];
    assign o_finish_y = w_prim_out.fin[AX_Y];
    assign o_last     = w_prim_out.last;

endmodule

// ===== rtl/psqp_fifo.sv =====
// Small first-in first-out queue built from flip-flops.
// Generic in width and depth; used between the front and the back and on the output.
// No package dependencies.
module psqp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow a lone push");

    a_cnt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not follow a lone pop");

endmodule

// ===== rtl/psqp_front.sv =====
// Front part: accepts path commands, keeps the pen, contour start and pen-down flag,
// and turns each drawing command given while the pen is down into one job for the back part.
// Depends on psqp_pkg.
module psqp_front #(
    parameter int CW = 24
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_push,
    input  logic [2:0]                                 i_action,
    input  logic [CW-1:0]                              i_point1_x,
    input  logic [CW-1:0]                              i_point1_y,
    input  logic [CW-1:0]                              i_point2_x,
    input  logic [CW-1:0]                              i_point2_y,
    input  logic [CW-1:0]                              i_point3_x,
    input  logic [CW-1:0]                              i_point3_y,
    input  logic                                       i_full,
    output logic                                       o_push,
    output logic [$bits(psqp_pkg::t_op)+8*CW-1:0]      o_job
);

    import psqp_pkg::*;

    typedef logic [1:0][CW-1:0] t_pt;

    typedef struct packed {
        t_op op;
        t_pt p0;
        t_pt p1;
        t_pt p2;
        t_pt p3;
    } t_job;

    t_pt  r_pen;
    t_pt  r_start;
    logic r_down;
    t_pt  n_pen;
    t_pt  n_start;
    logic n_down;
    t_pt  w_pt1;
    t_pt  w_pt2;
    t_pt  w_pt3;
    t_job w_job;
    logic w_acc;

    assign w_acc = i_push && !i_full;

    always_comb begin
        w_pt1[AX_X] = i_point1_x;
        w_pt1[AX_Y] = i_point1_y;
        w_pt2[AX_X] = i_point2_x;
        w_pt2[AX_Y] = i_point2_y;
        w_pt3[AX_X] = i_point3_x;
        w_pt3[AX_Y] = i_point3_y;
    end

    always_comb begin
        n_pen    = r_pen;
        n_start  = r_start;
        n_down   = r_down;
        o_push   = 1'b0;
        w_job    = '0;
        w_job.op = OP_LINE;
        w_job.p0 = r_pen;
        if (w_acc) begin
            case (i_action)
                ACT_MOVE: begin
                    n_pen   = w_pt1;
                    n_start = w_pt1;
                    n_down  = 1'b1;
                end
                ACT_LINE: begin
                    if (r_down) begin
                        o_push   = 1'b1;
                        w_job.p3 = w_pt1;
                        n_pen    = w_pt1;
                    end
                end
                ACT_QUAD: begin
                    if (r_down) begin
                        o_push   = 1'b1;
                        w_job.op = OP_QUAD;
                        w_job.p1 = w_pt1;
                        w_job.p3 = w_pt2;
                        n_pen    = w_pt2;
                    end
                end
                ACT_CUBIC: begin
                    if (r_down) begin
                        o_push   = 1'b1;
                        w_job.op = OP_CUBIC;
                        w_job.p1 = w_pt1;
                        w_job.p2 = w_pt2;
                        w_job.p3 = w_pt3;
                        n_pen    = w_pt3;
                    end
                end
                ACT_CLOSE: begin
                    if (r_down) begin
                        o_push   = 1'b1;
                        w_job.p3 = r_start;
                        n_pen    = r_start;
                        n_down   = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_job = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen   <= '0;
            r_start <= '0;
            r_down  <= 1'b0;
        end else begin
            r_pen   <= n_pen;
            r_start <= n_start;
            r_down  <= n_down;
        end
    end

endmodule

// ===== rtl/psqp_back.sv =====
// Back part: a six-stage midpoint pipeline that splits cubic jobs into four quadratics,
// and an emitter stage that issues one primitive per cycle to the output queue while it has room.
// Depends on psqp_pkg.
module psqp_back #(
    parameter int CW = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_job_valid,
    input  logic [$bits(psqp_pkg::t_op)+8*CW-1:0]  i_job,
    output logic                                   o_job_pop,
    input  logic                                   i_prim_full,
    output logic                                   o_prim_push,
    output logic [2+6*CW-1:0]                      o_prim
);

    import psqp_pkg::*;

    typedef logic [1:0][CW-1:0] t_pt;

    typedef struct packed {
        t_op op;
        t_pt p0;
        t_pt p1;
        t_pt p2;
        t_pt p3;
    } t_job;

    typedef struct packed {
        logic kind;
        t_pt  bgn;
        t_pt  ctl;
        t_pt  fin;
        logic last;
    } t_prim;

    localparam logic [1:0] PH_LAST = 2'd3;

    function automatic logic [CW-1:0] f_half(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    t_job  w_job;
    t_prim w_prim;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;
    logic w_emit;
    logic w_done;
    logic [1:0] r_ph;

    t_op r_op1, r_op2, r_op3, r_op4, r_op5, r_op6;
    t_pt r_p0_1, r_p0_2, r_p0_3, r_p0_4, r_p0_5, r_p0_6;
    t_pt r_p1_1, r_p1_2, r_p1_3, r_p1_4, r_p1_5, r_p1_6;
    t_pt r_p3_1, r_p3_2, r_p3_3, r_p3_4, r_p3_5, r_p3_6;

    t_pt r_m01_1, r_m12_1, r_m23_1;
    t_pt r_m01_2, r_m23_2, r_m001_2, r_m233_2, r_m0112_2, r_m1223_2;
    t_pt r_a_3, r_d_3, r_bb_3, r_m0112_3, r_m1223_3;
    t_pt r_a_4, r_d_4, r_bb_4, r_lb_4, r_rb_4, r_m0112_4, r_m1223_4;
    t_pt r_a_5, r_d_5, r_bb_5, r_b_5, r_c_5;
    t_pt r_a_6, r_b_6, r_bb_6, r_c_6, r_d_6, r_q1_6, r_q5_6;

    assign w_job = i_job;

    assign w_emit = r_v6 && !i_prim_full;
    assign w_done = w_emit && ((r_op6 != OP_CUBIC) || (r_ph == PH_LAST));
    assign w_rdy6 = !r_v6 || w_done;
    assign w_rdy5 = !r_v5 || w_rdy6;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_job_pop = i_job_valid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_ph <= '0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_job_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
            if (w_rdy6) begin
                r_v6 <= r_v5;
            end
            if (w_done) begin
                r_ph <= '0;
            end else if (w_emit) begin
                r_ph <= r_ph + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_op1  <= w_job.op;
            r_p0_1 <= w_job.p0;
            r_p1_1 <= w_job.p1;
            r_p3_1 <= w_job.p3;
            for (int k = 0; k < 2; k++) begin
                r_m01_1[k] <= f_half(w_job.p0[k], w_job.p1[k]);
                r_m12_1[k] <= f_half(w_job.p1[k], w_job.p2[k]);
                r_m23_1[k] <= f_half(w_job.p2[k], w_job.p3[k]);
            end
        end
        if (w_rdy2) begin
            r_op2     <= r_op1;
            r_p0_2    <= r_p0_1;
            r_p1_2    <= r_p1_1;
            r_p3_2    <= r_p3_1;
            r_m01_2   <= r_m01_1;
            r_m23_2   <= r_m23_1;
            for (int k = 0; k < 2; k++) begin
                r_m001_2[k]  <= f_half(r_p0_1[k], r_m01_1[k]);
                r_m233_2[k]  <= f_half(r_m23_1[k], r_p3_1[k]);
                r_m0112_2[k] <= f_half(r_m01_1[k], r_m12_1[k]);
                r_m1223_2[k] <= f_half(r_m12_1[k], r_m23_1[k]);
            end
        end
        if (w_rdy3) begin
            r_op3     <= r_op2;
            r_p0_3    <= r_p0_2;
            r_p1_3    <= r_p1_2;
            r_p3_3    <= r_p3_2;
            r_m0112_3 <= r_m0112_2;
            r_m1223_3 <= r_m1223_2;
            for (int k = 0; k < 2; k++) begin
                r_a_3[k]  <= f_half(r_m001_2[k], r_m01_2[k]);
                r_d_3[k]  <= f_half(r_m23_2[k], r_m233_2[k]);
                r_bb_3[k] <= f_half(r_m0112_2[k], r_m1223_2[k]);
            end
        end
        if (w_rdy4) begin
            r_op4     <= r_op3;
            r_p0_4    <= r_p0_3;
            r_p1_4    <= r_p1_3;
            r_p3_4    <= r_p3_3;
            r_a_4     <= r_a_3;
            r_d_4     <= r_d_3;
            r_bb_4    <= r_bb_3;
            r_m0112_4 <= r_m0112_3;
            r_m1223_4 <= r_m1223_3;
            for (int k = 0; k < 2; k++) begin
                r_lb_4[k] <= f_half(r_m0112_3[k], r_bb_3[k]);
                r_rb_4[k] <= f_half(r_bb_3[k], r_m1223_3[k]);
            end
        end
        if (w_rdy5) begin
            r_op5  <= r_op4;
            r_p0_5 <= r_p0_4;
            r_p1_5 <= r_p1_4;
            r_p3_5 <= r_p3_4;
            r_a_5  <= r_a_4;
            r_d_5  <= r_d_4;
            r_bb_5 <= r_bb_4;
            for (int k = 0; k < 2; k++) begin
                r_b_5[k] <= f_half(r_m0112_4[k], r_lb_4[k]);
                r_c_5[k] <= f_half(r_rb_4[k], r_m1223_4[k]);
            end
        end
        if (w_rdy6) begin
            r_op6  <= r_op5;
            r_p0_6 <= r_p0_5;
            r_p1_6 <= r_p1_5;
            r_p3_6 <= r_p3_5;
            r_a_6  <= r_a_5;
            r_b_6  <= r_b_5;
            r_bb_6 <= r_bb_5;
            r_c_6  <= r_c_5;
            r_d_6  <= r_d_5;
            for (int k = 0; k < 2; k++) begin
                r_q1_6[k] <= f_half(r_a_5[k], r_b_5[k]);
                r_q5_6[k] <= f_half(r_c_5[k], r_d_5[k]);
            end
        end
    end

    always_comb begin
        w_prim.kind = KIND_QUAD;
        w_prim.bgn  = r_p0_6;
        w_prim.ctl  = r_p1_6;
        w_prim.fin  = r_p3_6;
        w_prim.last = 1'b1;
        case (r_op6)
            OP_LINE: begin
                w_prim.kind = KIND_LINE;
            end
            OP_QUAD: begin
                w_prim.kind = KIND_QUAD;
            end
            OP_CUBIC: begin
                w_prim.last = (r_ph == PH_LAST);
                case (r_ph)
                    2'd0: begin
                        w_prim.ctl = r_a_6;
                        w_prim.fin = r_q1_6;
                    end
                    2'd1: begin
                        w_prim.bgn = r_q1_6;
                        w_prim.ctl = r_b_6;
                        w_prim.fin = r_bb_6;
                    end
                    2'd2: begin
                        w_prim.bgn = r_bb_6;
                        w_prim.ctl = r_c_6;
                        w_prim.fin = r_q5_6;
                    end
                    default: begin
                        w_prim.bgn = r_q5_6;
                        w_prim.ctl = r_d_6;
                    end
                endcase
            end
            default: begin
                w_prim.kind = KIND_LINE;
            end
        endcase
    end

    assign o_prim_push = w_emit;
    assign o_prim      = w_prim;

    a_ph_cubic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph != '0) |-> (r_v6 && (r_op6 == OP_CUBIC)))
        else $error("split phase set without a cubic in the emitter");

    a_ph_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_ph == PH_LAST)) |=> (r_ph == '0))
        else $error("split phase did not return to zero after the last quadratic");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && i_prim_full) |=> (r_v6 && $stable(r_ph)))
        else $error("emitter lost its request while the output queue was full");

endmodule

// ===== dv/psqp_tb_pkg.sv =====
`timescale 1ns / 1ps
// Checker class for the path command to quadratic primitive converter.
// It tracks the pen state, predicts primitives per request and checks them in order.
// Depends on psqp_pkg.
package psqp_tb_pkg;
    import psqp_pkg::*;

    localparam int CW = 24;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [2:0] action;
        t_coord     p1x;
        t_coord     p1y;
        t_coord     p2x;
        t_coord     p2y;
        t_coord     p3x;
        t_coord     p3y;
    } t_command;

    typedef struct packed {
        logic   kind;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
        t_coord fx;
        t_coord fy;
        logic   last;
    } t_prim;

    function automatic t_coord half_sum(input t_coord a, input t_coord b);
        logic [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    function automatic void split_axis(input t_coord p0, input t_coord p1, input t_coord p2,
                                       input t_coord p3, output t_coord q[7]);
        t_coord m01, m12, m23, m001, m233, m0112, m1223, bb, lb, rb, a, b, c, d;
        m01   = half_sum(p0, p1);
        m12   = half_sum(p1, p2);
        m23   = half_sum(p2, p3);
        m001  = half_sum(p0, m01);
        a     = half_sum(m001, m01);
        m233  = half_sum(m23, p3);
        d     = half_sum(m23, m233);
        m0112 = half_sum(m01, m12);
        m1223 = half_sum(m12, m23);
        bb    = half_sum(m0112, m1223);
        lb    = half_sum(m0112, bb);
        b     = half_sum(m0112, lb);
        rb    = half_sum(bb, m1223);
        c     = half_sum(rb, m1223);
        q[0] = a;
        q[1] = half_sum(a, b);
        q[2] = b;
        q[3] = bb;
        q[4] = c;
        q[5] = half_sum(c, d);
        q[6] = d;
    endfunction

    class path_primitive_checker;
        t_coord pen_x = '0;
        t_coord pen_y = '0;
        t_coord start_x = '0;
        t_coord start_y = '0;
        bit     pen_down = 1'b0;
        t_prim  pending_prims[$];
        int     mismatches = 0;
        int     n_commands = 0;
        int     n_active = 0;
        int     n_ignored = 0;
        int     n_cubics = 0;
        int     n_closes = 0;
        int     n_prims = 0;

        function void add(input logic kind, input t_coord bx, input t_coord by,
                          input t_coord cx, input t_coord cy, input t_coord fx,
                          input t_coord fy, input logic last);
            t_prim p;
            p = '{kind, bx, by, cx, cy, fx, fy, last};
            pending_prims = {pending_prims, p};
        endfunction

        function void note_command(input t_command c);
            t_coord qx[7];
            t_coord qy[7];
            n_commands++;
            if (c.action == ACT_MOVE) begin
                pen_x = c.p1x;
                pen_y = c.p1y;
                start_x = c.p1x;
                start_y = c.p1y;
                pen_down = 1'b1;
                n_active++;
                return;
            end
            if (c.action > ACT_CLOSE || !pen_down) begin
                n_ignored++;
                return;
            end
            n_active++;
            case (c.action)
                ACT_LINE: begin
                    add(KIND_LINE, pen_x, pen_y, '0, '0, c.p1x, c.p1y, 1'b1);
                    pen_x = c.p1x;
                    pen_y = c.p1y;
                end
                ACT_QUAD: begin
                    add(KIND_QUAD, pen_x, pen_y, c.p1x, c.p1y, c.p2x, c.p2y, 1'b1);
                    pen_x = c.p2x;
                    pen_y = c.p2y;
                end
                ACT_CUBIC: begin
                    split_axis(pen_x, c.p1x, c.p2x, c.p3x, qx);
                    split_axis(pen_y, c.p1y, c.p2y, c.p3y, qy);
                    add(KIND_QUAD, pen_x, pen_y, qx[0], qy[0], qx[1], qy[1], 1'b0);
                    add(KIND_QUAD, qx[1], qy[1], qx[2], qy[2], qx[3], qy[3], 1'b0);
                    add(KIND_QUAD, qx[3], qy[3], qx[4], qy[4], qx[5], qy[5], 1'b0);
                    add(KIND_QUAD, qx[5], qy[5], qx[6], qy[6], c.p3x, c.p3y, 1'b1);
                    pen_x = c.p3x;
                    pen_y = c.p3y;
                    n_cubics++;
                end
                default: begin
                    add(KIND_LINE, pen_x, pen_y, '0, '0, start_x, start_y, 1'b1);
                    pen_x = start_x;
                    pen_y = start_y;
                    pen_down = 1'b0;
                    n_closes++;
                end
            endcase
        endfunction

        function void report(input string what, input t_prim e, input t_prim g);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected kind %0d begin (%0d,%0d) ctrl (%0d,%0d) end (%0d,%0d) last %0d",
                         what, e.kind, e.bx, e.by, e.cx, e.cy, e.fx, e.fy, e.last);
                $display("    actual kind %0d begin (%0d,%0d) ctrl (%0d,%0d) end (%0d,%0d) last %0d",
                         g.kind, g.bx, g.by, g.cx, g.cy, g.fx, g.fy, g.last);
            end
        endfunction

        function void check_primitive(input t_prim got);
            t_prim want;
            if (pending_prims.size() == 0) begin
                report("primitive with no request behind it", '0, got);
                return;
            end
            want = pending_prims.pop_front();
            n_prims++;
            if (got.kind !== want.kind || got.bx !== want.bx || got.by !== want.by ||
                got.cx !== want.cx || got.cy !== want.cy || got.fx !== want.fx ||
                got.fy !== want.fy || got.last !== want.last) begin
                report("primitive mismatch", want, got);
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level testbench of path_segments_to_quad_primitives.
// Drives directed and random path requests under varying idle mixes and checks every primitive.
// Depends on psqp_pkg, psqp_tb_pkg and the RTL.
module tb_top;
    import psqp_pkg::*;
    import psqp_tb_pkg::*;

    localparam int     LIMIT       = 200000;
    localparam int     HOLD_CYCLES = 300;
    localparam t_coord C_MAX       = 24'sh7FFFFF;
    localparam t_coord C_MIN       = 24'sh800000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push = 1'b0;
    logic       i_pop = 1'b0;
    logic [2:0] i_action = '0;
    t_coord     i_point1_x = '0;
    t_coord     i_point1_y = '0;
    t_coord     i_point2_x = '0;
    t_coord     i_point2_y = '0;
    t_coord     i_point3_x = '0;
    t_coord     i_point3_y = '0;
    logic       o_full;
    logic       o_empty;
    logic       o_kind;
    t_coord     o_begin_x;
    t_coord     o_begin_y;
    t_coord     o_ctrl_x;
    t_coord     o_ctrl_y;
    t_coord     o_finish_x;
    t_coord     o_finish_y;
    logic       o_last;

    path_primitive_checker sb = new();
    int cycles = 0;
    int push_idle_pct = 0;
    int pop_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;

    path_segments_to_quad_primitives #(.COORD_WIDTH(CW)) dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else if (i_rst_n && i_pop && !o_empty) begin
            sb.check_primitive('{o_kind, o_begin_x, o_begin_y, o_ctrl_x, o_ctrl_y,
                                 o_finish_x, o_finish_y, o_last});
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop = 1'b0;
            end else begin
                i_pop = ($urandom_range(99) >= pop_idle_pct);
            end
        end
    end

    function automatic t_coord rand_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) begin
            return t_coord'($urandom);
        end else if (sel < 42) begin
            case ($urandom_range(4))
                0: return C_MAX;
                1: return C_MIN;
                2: return '0;
                3: return '1;
                default: return t_coord'(1);
            endcase
        end
        return t_coord'(int'($urandom_range(8191)) - 4096);
    endfunction

    function automatic t_command cmd(input logic [2:0] act, input t_coord p1x, input t_coord p1y,
                                     input t_coord p2x, input t_coord p2y, input t_coord p3x,
                                     input t_coord p3y);
        return '{act, p1x, p1y, p2x, p2y, p3x, p3y};
    endfunction

    function automatic t_command rand_cmd(input logic [2:0] act);
        return cmd(act, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord());
    endfunction

    task automatic send_command(input t_command c);
        while ($urandom_range(99) < push_idle_pct) begin
            @(negedge i_clk);
            i_push = 1'b0;
        end
        @(negedge i_clk);
        i_push = 1'b1;
        i_action = c.action;
        i_point1_x = c.p1x;
        i_point1_y = c.p1y;
        i_point2_x = c.p2x;
        i_point2_y = c.p2y;
        i_point3_x = c.p3x;
        i_point3_y = c.p3y;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sb.note_command(c);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_push = 1'b0;
        while (sb.pending_prims.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_contours(input int target);
        int goal;
        int n;
        int sel;
        goal = sb.n_active + target;
        while (sb.n_active < goal) begin
            if ($urandom_range(99) < 15) begin
                send_command(rand_cmd(3'($urandom_range(7))));
            end else begin
                send_command(rand_cmd(ACT_MOVE));
                n = $urandom_range(8, 1);
                repeat (n) begin
                    sel = $urandom_range(9);
                    if (sel < 3) send_command(rand_cmd(ACT_LINE));
                    else if (sel < 6) send_command(rand_cmd(ACT_QUAD));
                    else send_command(rand_cmd(ACT_CUBIC));
                end
                if ($urandom_range(99) < 80) send_command(rand_cmd(ACT_CLOSE));
            end
        end
    endtask

    initial begin
        int errors;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_command(cmd(ACT_LINE, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_command(cmd(ACT_CLOSE, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_command(cmd(ACT_MOVE, C_MAX, C_MIN, '1, '1, '1, '1));
        send_command(cmd(ACT_LINE, C_MIN, C_MAX, '0, '0, '1, '1));
        send_command(cmd(ACT_QUAD, C_MAX, C_MAX, C_MIN, C_MIN, '1, '0));
        send_command(cmd(ACT_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        send_command(cmd(ACT_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_command(cmd(ACT_CUBIC, 24'sd1, -24'sd1, 24'sd3, -24'sd3, -24'sd5, 24'sd7));
        send_command(cmd(3'd5, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_command(cmd(3'd6, '0, '0, '0, '0, '0, '0));
        send_command(cmd(3'd7, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
        send_command(cmd(ACT_CLOSE, '0, '0, '0, '0, '0, '0));
        send_command(rand_cmd(ACT_QUAD));
        send_command(rand_cmd(ACT_CUBIC));
        send_command(rand_cmd(ACT_CLOSE));
        send_command(cmd(ACT_MOVE, '0, '0, C_MAX, C_MIN, C_MAX, C_MIN));
        send_command(cmd(ACT_MOVE, '1, '1, '0, '0, '0, '0));
        send_command(cmd(ACT_CUBIC, '1, '1, '1, '1, '1, '1));
        send_command(cmd(ACT_LINE, '0, '0, C_MIN, C_MAX, C_MIN, C_MAX));
        send_command(cmd(ACT_CLOSE, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_command(rand_cmd(ACT_MOVE));
        send_command(rand_cmd(ACT_CLOSE));
        wait_drained();

        push_idle_pct = 20;
        pop_idle_pct = 71;
        hold_req = 1'b1;
        send_command(rand_cmd(ACT_MOVE));
        repeat (40) send_command(rand_cmd(ACT_CUBIC));
        wait_drained();
        run_contours(80);
        wait_drained();

        push_idle_pct = 71;
        pop_idle_pct = 20;
        run_contours(90);
        wait_drained();

        push_idle_pct = 0;
        pop_idle_pct = 0;
        run_contours(90);

        @(negedge i_clk);
        i_push = 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);

        errors = sb.mismatches + sb.pending_prims.size();
        if (sb.pending_prims.size() != 0)
            $display("tb_top: %0d expected primitives never arrived", sb.pending_prims.size());
        $display("tb_top: %0d requests accepted (%0d ignored), %0d cubics split, %0d closes",
                 sb.n_commands, sb.n_ignored, sb.n_cubics, sb.n_closes);
        $display("tb_top: %0d primitives checked over three idle mixes and a long output stall",
                 sb.n_prims);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
